// ===== sv/three_phase_spwm_threshold_gen_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-phase SPWM threshold generator
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_SPWM_THRESHOLD_GEN_TOP_MACROS_SVH
`define THREE_PHASE_SPWM_THRESHOLD_GEN_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked while the block is out of reset.
`define TPSG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TPSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TPSG_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPSG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/tpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-phase SPWM threshold generator package
// Shared widths, register codes, reset values and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsg_pkg;

  localparam int PHASE_BITS_DEF = 16;

  localparam int PHASE_STEP_W = 16;
  localparam int MIN_WIDTH_W  = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam int SAMPLE_W    = 13;
  localparam int OUT_W       = 13;
  localparam int TABLE_BITS  = 6;
  localparam int TABLE_IDX_W = TABLE_BITS + 1;

  localparam logic [SAMPLE_W-1:0] PERIOD_VAL  = 13'd4096;
  localparam logic [OUT_W-1:0]    HALF_PERIOD = 13'd2048;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH  = 1'b1;

  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 16'd150;
  localparam logic [MIN_WIDTH_W-1:0]  MIN_WIDTH_RST  = 11'd600;

  // Quarter-wave sine, entry i is round(sin(i*pi/128)*2048 + 2048).
  function automatic logic [SAMPLE_W-1:0] sine_rom(input logic [TABLE_IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] v;
    case (idx)
      7'd0:  v = 13'd2048;  7'd1:  v = 13'd2098;  7'd2:  v = 13'd2148;
      7'd3:  v = 13'd2199;  7'd4:  v = 13'd2249;  7'd5:  v = 13'd2299;
      7'd6:  v = 13'd2349;  7'd7:  v = 13'd2398;  7'd8:  v = 13'd2448;
      7'd9:  v = 13'd2497;  7'd10: v = 13'd2546;  7'd11: v = 13'd2594;
      7'd12: v = 13'd2643;  7'd13: v = 13'd2690;  7'd14: v = 13'd2738;
      7'd15: v = 13'd2785;  7'd16: v = 13'd2832;  7'd17: v = 13'd2878;
      7'd18: v = 13'd2924;  7'd19: v = 13'd2969;  7'd20: v = 13'd3013;
      7'd21: v = 13'd3057;  7'd22: v = 13'd3101;  7'd23: v = 13'd3144;
      7'd24: v = 13'd3186;  7'd25: v = 13'd3227;  7'd26: v = 13'd3268;
      7'd27: v = 13'd3308;  7'd28: v = 13'd3347;  7'd29: v = 13'd3386;
      7'd30: v = 13'd3423;  7'd31: v = 13'd3460;  7'd32: v = 13'd3496;
      7'd33: v = 13'd3531;  7'd34: v = 13'd3565;  7'd35: v = 13'd3599;
      7'd36: v = 13'd3631;  7'd37: v = 13'd3663;  7'd38: v = 13'd3693;
      7'd39: v = 13'd3722;  7'd40: v = 13'd3751;  7'd41: v = 13'd3778;
      7'd42: v = 13'd3805;  7'd43: v = 13'd3830;  7'd44: v = 13'd3854;
      7'd45: v = 13'd3877;  7'd46: v = 13'd3899;  7'd47: v = 13'd3920;
      7'd48: v = 13'd3940;  7'd49: v = 13'd3959;  7'd50: v = 13'd3976;
      7'd51: v = 13'd3993;  7'd52: v = 13'd4008;  7'd53: v = 13'd4022;
      7'd54: v = 13'd4035;  7'd55: v = 13'd4046;  7'd56: v = 13'd4057;
      7'd57: v = 13'd4066;  7'd58: v = 13'd4074;  7'd59: v = 13'd4081;
      7'd60: v = 13'd4086;  7'd61: v = 13'd4090;  7'd62: v = 13'd4094;
      7'd63: v = 13'd4095;  7'd64: v = 13'd4096;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tpsg_sine_lut.sv =====
// ----------------------------------------------------------------------------
// SPWM sine lookup
// Turns one phase into a clamped sine sample: quadrant mirroring, quarter-wave
// ROM read, linear interpolation on the fraction bits and margin clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsg_sine_lut #(
  parameter int PHASE_BITS = tpsg_pkg::PHASE_BITS_DEF
) (
  input  wire logic [PHASE_BITS-1:0]            phase,
  input  wire logic [tpsg_pkg::MIN_WIDTH_W-1:0] min_width,
  output logic      [tpsg_pkg::SAMPLE_W-1:0]    sample
);

  localparam int QUAD_BITS = PHASE_BITS - 2;
  localparam int FRAC_BITS = QUAD_BITS - tpsg_pkg::TABLE_BITS;
  localparam int PROD_W    = tpsg_pkg::SAMPLE_W + FRAC_BITS;
  localparam logic [QUAD_BITS:0] QUAD_FULL = {1'b1, {QUAD_BITS{1'b0}}};

  logic [1:0]                           quadrant;
  logic [QUAD_BITS:0]                   angle;
  logic [QUAD_BITS:0]                   angle_m;
  logic [tpsg_pkg::TABLE_IDX_W-1:0]     area;
  logic [tpsg_pkg::TABLE_IDX_W-1:0]     area_p1;
  logic [FRAC_BITS-1:0]                 frac;
  logic [tpsg_pkg::SAMPLE_W-1:0]        t0;
  logic [tpsg_pkg::SAMPLE_W-1:0]        t1;
  logic [tpsg_pkg::SAMPLE_W-1:0]        diff;
  logic [PROD_W-1:0]                    prod;
  logic [tpsg_pkg::SAMPLE_W-1:0]        interp;
  logic [tpsg_pkg::SAMPLE_W-1:0]        val;
  logic [tpsg_pkg::SAMPLE_W-1:0]        val_q;
  logic [tpsg_pkg::SAMPLE_W-1:0]        lo_bound;
  logic [tpsg_pkg::SAMPLE_W-1:0]        hi_bound;

  always_comb begin
    quadrant = phase[PHASE_BITS-1 -: 2];
    angle    = {1'b0, phase[QUAD_BITS-1:0]};
    angle_m  = quadrant[0] ? (QUAD_FULL - angle) : angle;
    area     = angle_m[QUAD_BITS -: tpsg_pkg::TABLE_IDX_W];
    frac     = angle_m[FRAC_BITS-1:0];
    area_p1  = area + tpsg_pkg::TABLE_IDX_W'(1);

    t0     = tpsg_pkg::sine_rom(area);
    t1     = tpsg_pkg::sine_rom(area_p1);
    diff   = t1 - t0;
    prod   = PROD_W'(diff) * PROD_W'(frac);
    interp = t0 + prod[PROD_W-1:FRAC_BITS];
    val    = (frac == '0) ? t0 : interp;
    val_q  = quadrant[1] ? (tpsg_pkg::PERIOD_VAL - val) : val;

    lo_bound = tpsg_pkg::SAMPLE_W'(min_width);
    hi_bound = tpsg_pkg::PERIOD_VAL - lo_bound;
    if (val_q > hi_bound) begin
      sample = hi_bound;
    end else if (val_q < lo_bound) begin
      sample = lo_bound;
    end else begin
      sample = val_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/three_phase_spwm_threshold_gen_top.sv =====
// ----------------------------------------------------------------------------
// Three-phase SPWM threshold generator
// Each accepted tick word with period_tick high advances the U, V and W
// phase accumulators by the phase step; the registered phases are looked
// up in the quarter-wave sine ROM, clamped by the minimum width and turned
// into a centered low/high compare pair per phase. A word is taken every
// cycle while in_ready is high; one with period_tick low produces no result
// word. Each result passes the phase, then the result registers; a stalled
// result stage holds one word while one more waits in the phase registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_phase_spwm_threshold_gen_top_macros.svh"

module three_phase_spwm_threshold_gen_top #(
  parameter int PHASE_BITS = tpsg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              cfg_we,
  input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tpsg_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_period_tick,

  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [tpsg_pkg::OUT_W-1:0]        out_u_low,
  output logic      [tpsg_pkg::OUT_W-1:0]        out_u_high,
  output logic      [tpsg_pkg::OUT_W-1:0]        out_v_low,
  output logic      [tpsg_pkg::OUT_W-1:0]        out_v_high,
  output logic      [tpsg_pkg::OUT_W-1:0]        out_w_low,
  output logic      [tpsg_pkg::OUT_W-1:0]        out_w_high
);

  localparam logic [PHASE_BITS-1:0] PHASE_THIRD = PHASE_BITS'((2 ** PHASE_BITS) / 3);
  localparam logic [PHASE_BITS-1:0] PHASE_TWO_THIRDS = PHASE_BITS'(2 * ((2 ** PHASE_BITS) / 3));

  logic [tpsg_pkg::PHASE_STEP_W-1:0] phase_step_r, phase_step_nxt;
  logic [tpsg_pkg::MIN_WIDTH_W-1:0]  min_width_r, min_width_nxt;
  logic [PHASE_BITS-1:0]             phase_u_r, phase_u_nxt;
  logic [PHASE_BITS-1:0]             phase_v_r, phase_v_nxt;
  logic [PHASE_BITS-1:0]             phase_w_r, phase_w_nxt;
  logic                              stg_valid_r, stg_valid_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [tpsg_pkg::OUT_W-1:0]        u_low_r, u_high_r, v_low_r, v_high_r, w_low_r, w_high_r;

  logic                              out_free;
  logic                              stg_adv;
  logic                              tick_acc;
  logic [PHASE_BITS-1:0]             step_ext;
  logic [tpsg_pkg::SAMPLE_W-1:0]     u_sample, v_sample, w_sample;
  logic [tpsg_pkg::OUT_W-1:0]        u_half, v_half, w_half;

  assign out_free = !out_valid_r || out_ready;
  assign stg_adv  = stg_valid_r && out_free;
  assign in_ready = !stg_valid_r || out_free;
  assign tick_acc = in_valid && in_ready && in_period_tick;
  assign step_ext = PHASE_BITS'(phase_step_r);

  always_comb begin
    phase_step_nxt = phase_step_r;
    min_width_nxt  = min_width_r;
    if (cfg_we) begin
      case (cfg_index)
        tpsg_pkg::CFG_PHASE_STEP: phase_step_nxt = cfg_wdata;
        tpsg_pkg::CFG_MIN_WIDTH:  min_width_nxt  = cfg_wdata[tpsg_pkg::MIN_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_u_nxt = tick_acc ? (phase_u_r + step_ext) : phase_u_r;
    phase_v_nxt = tick_acc ? (phase_v_r + step_ext) : phase_v_r;
    phase_w_nxt = tick_acc ? (phase_w_r + step_ext) : phase_w_r;

    if (tick_acc) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_valid_nxt = 1'b0;
    end else begin
      stg_valid_nxt = stg_valid_r;
    end

    if (stg_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= tpsg_pkg::PHASE_STEP_RST;
      min_width_r  <= tpsg_pkg::MIN_WIDTH_RST;
      phase_u_r    <= '0;
      phase_v_r    <= PHASE_THIRD;
      phase_w_r    <= PHASE_TWO_THIRDS;
      stg_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_step_r <= phase_step_nxt;
      min_width_r  <= min_width_nxt;
      phase_u_r    <= phase_u_nxt;
      phase_v_r    <= phase_v_nxt;
      phase_w_r    <= phase_w_nxt;
      stg_valid_r  <= stg_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  tpsg_sine_lut #(.PHASE_BITS(PHASE_BITS)) u_lut_u (
    .phase     (phase_u_r),
    .min_width (min_width_r),
    .sample    (u_sample)
  );

  tpsg_sine_lut #(.PHASE_BITS(PHASE_BITS)) u_lut_v (
    .phase     (phase_v_r),
    .min_width (min_width_r),
    .sample    (v_sample)
  );

  tpsg_sine_lut #(.PHASE_BITS(PHASE_BITS)) u_lut_w (
    .phase     (phase_w_r),
    .min_width (min_width_r),
    .sample    (w_sample)
  );

  assign u_half = {1'b0, u_sample[tpsg_pkg::SAMPLE_W-1:1]};
  assign v_half = {1'b0, v_sample[tpsg_pkg::SAMPLE_W-1:1]};
  assign w_half = {1'b0, w_sample[tpsg_pkg::SAMPLE_W-1:1]};

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      u_low_r  <= tpsg_pkg::HALF_PERIOD - u_half;
      u_high_r <= tpsg_pkg::HALF_PERIOD + u_half;
      v_low_r  <= tpsg_pkg::HALF_PERIOD - v_half;
      v_high_r <= tpsg_pkg::HALF_PERIOD + v_half;
      w_low_r  <= tpsg_pkg::HALF_PERIOD - w_half;
      w_high_r <= tpsg_pkg::HALF_PERIOD + w_half;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_u_low  = u_low_r;
  assign out_u_high = u_high_r;
  assign out_v_low  = v_low_r;
  assign out_v_high = v_high_r;
  assign out_w_low  = w_low_r;
  assign out_w_high = w_high_r;

  `TPSG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!stg_valid_r && !out_valid_r), "Pipeline not empty after reset.")
  `TPSG_ASSERT(a_tick_loads_stage, clk, rst_n, tick_acc |=> stg_valid_r, "Accepted tick word did not reach the phase stage.")
  `TPSG_ASSERT(a_stage_to_out, clk, rst_n, stg_adv |=> out_valid_r, "Phase stage advanced without a result word.")
  `TPSG_ASSERT(a_phase_spacing, clk, rst_n, ((phase_v_r - phase_u_r) == PHASE_THIRD) && ((phase_w_r - phase_u_r) == PHASE_TWO_THIRDS), "Phase accumulators lost their spacing.")
  `TPSG_ASSERT(a_u_centered, clk, rst_n, out_valid_r |-> (({1'b0, out_u_low} + {1'b0, out_u_high}) == 14'd4096), "Phase U thresholds not centered.")

endmodule

`default_nettype wire
